// File: rtl/core/ssd_pkg.sv
// Shared types, constants and helpers for the scratchpad decoder.
// No dependencies; imported by every module of the block.
package ssd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned TEMP_W      = 18;
    localparam int unsigned RES_W       = 4;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned ACC_W       = 19;
    localparam int unsigned FIX_W       = 12;
    localparam int unsigned SCALE_W     = 7;

    localparam logic [BYTE_W-1:0]  CRC_POLY       = 8'h8C;
    localparam logic [3:0]         FRAME_LAST     = 4'd8;
    localparam logic [3:0]         IDX_RAW_LOW    = 4'd0;
    localparam logic [3:0]         IDX_RAW_HIGH   = 4'd1;
    localparam logic [3:0]         IDX_CONFIG     = 4'd4;
    localparam logic [SCALE_W-1:0] MILLI_PER_16TH = 7'd125;
    localparam logic [RES_W-1:0]   RES_BASE       = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CRC,
        ST_MUL,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
    } t_crc_ctl;

    // Fraction bits kept for each resolution code, 9 to 12 bits.
    function automatic logic [3:0] frac_mask(input logic [1:0] code);
        logic [3:0] m;
        unique case (code)
            2'd0:    m = 4'b1000;
            2'd1:    m = 4'b1100;
            2'd2:    m = 4'b1110;
            default: m = 4'b1111;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/core/ssd_crc_bitser.sv
// Bit-serial reflected CRC-8 (poly 0x8C), one bit per cycle.
// Depends on ssd_pkg.
module ssd_crc_bitser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ssd_pkg::t_crc_ctl          i_ctl,
    input  logic [ssd_pkg::BYTE_W-1:0] i_byte,
    output logic [ssd_pkg::BYTE_W-1:0] o_crc,
    output logic                       o_busy
);
    import ssd_pkg::*;

    logic [BYTE_W-1:0] r_crc, n_crc;
    logic [BYTE_W-2:0] r_data, n_data;
    logic [2:0]        r_steps, n_steps;
    logic              data_bit;
    logic              fb;
    logic [BYTE_W-1:0] stepped;

    always_comb begin
        // first bit is taken straight from the input on the load cycle
        data_bit = i_ctl.load ? i_byte[0] : r_data[0];
        fb       = r_crc[0] ^ data_bit;
        stepped  = {1'b0, r_crc[BYTE_W-1:1]} ^ (fb ? CRC_POLY : '0);

        n_crc   = r_crc;
        n_data  = r_data;
        n_steps = r_steps;
        if (i_ctl.clear) begin
            n_crc   = '0;
            n_steps = '0;
        end else if (i_ctl.load) begin
            n_crc   = stepped;
            n_data  = i_byte[BYTE_W-1:1];
            n_steps = 3'd7;
        end else if (r_steps != '0) begin
            n_crc   = stepped;
            n_data  = {1'b0, r_data[BYTE_W-2:1]};
            n_steps = r_steps - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= '0;
            r_steps <= '0;
        end else begin
            r_crc   <= n_crc;
            r_steps <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_crc  = r_crc;
    assign o_busy = (r_steps != '0);

endmodule

// File: rtl/core/ssd_temp_mul.sv
// Temperature conversion: raw word to millidegrees with a shift-add multiply by 125,
// one multiplier bit per cycle. Depends on ssd_pkg.
module ssd_temp_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [15:0]                      i_word,
    input  logic [1:0]                       i_res_code,
    output logic                             o_busy,
    output logic signed [ssd_pkg::TEMP_W-1:0] o_milli
);
    import ssd_pkg::*;

    logic                    r_neg, n_neg;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [ACC_W-1:0] r_mcand, n_mcand;
    logic [SCALE_W-1:0]      r_bits, n_bits;
    logic [15:0]             mag;
    logic signed [FIX_W-1:0] fix;
    logic signed [ACC_W-1:0] signed_half;
    logic signed [ACC_W-1:0] rounded;

    always_comb begin
        // magnitude, then integer part and kept fraction in 1/16 steps
        mag = i_word[15] ? (~i_word + 16'd1) : i_word;
        fix = $signed({mag[11:4], mag[3:0] & frac_mask(i_res_code)});

        n_neg   = r_neg;
        n_acc   = r_acc;
        n_mcand = r_mcand;
        n_bits  = r_bits;
        if (i_start) begin
            n_neg   = i_word[15];
            n_acc   = '0;
            n_mcand = ACC_W'(fix);
            n_bits  = MILLI_PER_16TH;
        end else if (r_bits != '0) begin
            if (r_bits[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand = r_mcand <<< 1;
            n_bits  = {1'b0, r_bits[SCALE_W-1:1]};
        end

        // apply sign, then halve toward zero
        signed_half = r_neg ? -r_acc : r_acc;
        rounded     = signed_half + ACC_W'(signed_half[ACC_W-1]);
        o_milli     = rounded[ACC_W-1:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else begin
            r_bits <= n_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
    end

    assign o_busy = (r_bits != '0);

endmodule

// File: rtl/core/sensor_scratchpad_decoder.sv
// Scratchpad decoder top level: frame control, CRC check and result register.
// Depends on ssd_pkg, ssd_crc_bitser and ssd_temp_mul.
//
// Usage:
//   Input stream: one scratchpad byte per item, bytes 0 to 8 of a frame in order.
//   Output stream: one result item per frame, after byte 8 is taken.
//   Bytes 0 to 7: the CRC unit consumes one bit per cycle, and o_s_tready
//   stays low until that unit is idle and ST_CRC has gone back to ST_IDLE.
//   Byte 8 is compared with the CRC at acceptance. On a mismatch the error
//   result goes through ST_HOLD into the output register, and the next byte
//   can be taken once ST_HOLD has written it; on a match the multiply by 125
//   runs one multiplier bit per cycle, then ST_HOLD registers the result and
//   the next byte can be taken after that.
//   The output register lets the next frame's bytes be taken while a result
//   waits. If a result is still held when the next one is ready, the block
//   holds the new one and takes no input until the receiver accepts.
//   Reset (synchronous, active low) clears the byte index, CRC and output valid flag;
//   the next byte after reset is byte 0 of a frame.
module sensor_scratchpad_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ssd_pkg::IN_TDATA_W-1:0]   i_s_tdata,  // [7:0] scratch_byte
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [0] status, [18:1] temperature_milli, [22:19] resolution_bits, [23] zero
    output logic [ssd_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import ssd_pkg::*;

    t_state                   r_state, n_state;
    logic [3:0]               r_byte_idx, n_byte_idx;
    logic [BYTE_W-1:0]        r_raw_low, n_raw_low;
    logic [BYTE_W-1:0]        r_raw_high, n_raw_high;
    logic [1:0]               r_res_code, n_res_code;
    logic                     r_err, n_err;
    logic                     r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0]   r_out_data, n_out_data;

    logic                     in_accept;
    logic                     crc_ok;
    t_crc_ctl                 crc_ctl;
    logic [BYTE_W-1:0]        crc_value;
    logic                     crc_busy;
    logic                     mul_start;
    logic                     mul_busy;
    logic signed [TEMP_W-1:0] milli;
    logic [TEMP_W-1:0]        res_temp;
    logic [RES_W-1:0]         res_bits;

    ssd_crc_bitser u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .i_byte  (i_s_tdata),
        .o_crc   (crc_value),
        .o_busy  (crc_busy)
    );

    ssd_temp_mul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mul_start),
        .i_word     ({r_raw_high, r_raw_low}),
        .i_res_code (r_res_code),
        .o_busy     (mul_busy),
        .o_milli    (milli)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign crc_ok     = (i_s_tdata == crc_value);

    always_comb begin
        n_state     = r_state;
        n_byte_idx  = r_byte_idx;
        n_raw_low   = r_raw_low;
        n_raw_high  = r_raw_high;
        n_res_code  = r_res_code;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        crc_ctl     = '0;
        mul_start   = 1'b0;

        res_temp = r_err ? '0 : milli;
        res_bits = r_err ? '0 : (RES_BASE + RES_W'(r_res_code));

        // drop the held result once the receiver takes it
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (r_byte_idx == FRAME_LAST) begin
                        crc_ctl.clear = 1'b1;
                        n_byte_idx    = '0;
                        n_err         = !crc_ok;
                        if (crc_ok) begin
                            mul_start = 1'b1;
                            n_state   = ST_MUL;
                        end else begin
                            n_state   = ST_HOLD;
                        end
                    end else begin
                        crc_ctl.load = 1'b1;
                        n_byte_idx   = r_byte_idx + 4'd1;
                        n_state      = ST_CRC;
                        if (r_byte_idx == IDX_RAW_LOW) begin
                            n_raw_low = i_s_tdata;
                        end else if (r_byte_idx == IDX_RAW_HIGH) begin
                            n_raw_high = i_s_tdata;
                        end else if (r_byte_idx == IDX_CONFIG) begin
                            n_res_code = i_s_tdata[6:5];
                        end
                    end
                end
            end
            ST_CRC: begin
                if (!crc_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL: begin
                if (!mul_busy) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, res_bits, res_temp, r_err};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_byte_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_byte_idx  <= n_byte_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw_low  <= n_raw_low;
        r_raw_high <= n_raw_high;
        r_res_code <= n_res_code;
        r_err      <= n_err;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_idx <= FRAME_LAST)
        else $error("byte index beyond frame end");

    a_ready_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!crc_busy && !mul_busy))
        else $error("input ready while a serial unit is busy");

    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> (o_m_tdata[OUT_TDATA_W-1:1] == '0))
        else $error("error result carries nonzero fields");

    a_ok_resolution: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[22:19] >= RES_BASE))
        else $error("ok result with resolution below nine bits");

    a_byte8_clears_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_byte_idx == FRAME_LAST) |=> (crc_value == '0 && r_byte_idx == '0))
        else $error("frame end did not restart CRC and index");
`endif

endmodule

// File: tb/sv/sensor_scratchpad_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sensor_scratchpad_decoder: streams scratchpad frames
// and checks each decoded result. Depends on ssd_pkg and the decoder RTL.
module sensor_scratchpad_decoder_tb;

    import ssd_pkg::*;

    localparam int          NUM_FRAMES  = 178;
    localparam int          MAX_WAIT    = 11;
    localparam logic        STATUS_OK   = 1'b0;
    localparam logic        STATUS_CRC  = 1'b1;

    // Result layout, lowest bit first: status, temperature, resolution, pad.
    typedef struct packed {
        logic                     pad;
        logic [RES_W-1:0]         res;
        logic signed [TEMP_W-1:0] temp;
        logic                     status;
    } t_decoded;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;   // [7:0] scratch_byte
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    // [0] status, [18:1] temperature_milli, [22:19] resolution_bits, [23] zero
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    bit tx_burst;
    bit rx_burst;

    sensor_scratchpad_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Reflected CRC-8, one byte, least significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic fb;
        for (int k = 0; k < 8; k++) begin
            fb   = crc[0] ^ data[0];
            crc  = crc >> 1;
            if (fb)
                crc = crc ^ CRC_POLY;
            data = data >> 1;
        end
        return crc;
    endfunction

    // Millidegrees from the raw word, with the fraction cut to the resolution.
    function automatic logic [TEMP_W-1:0] milli_degrees(input logic [15:0] word,
                                                        input logic [1:0] code);
        logic              neg;
        logic [15:0]       mag;
        logic signed [7:0] whole;
        logic [3:0]        keep;
        int                half;
        neg   = word[15];
        mag   = neg ? (~word + 16'd1) : word;
        whole = mag[11:4];
        case (code)
            2'd0:    keep = mag[3:0] & 4'b1000;
            2'd1:    keep = mag[3:0] & 4'b1100;
            2'd2:    keep = mag[3:0] & 4'b1110;
            default: keep = mag[3:0];
        endcase
        half = int'(whole) * 2000 + int'(keep) * 125;
        if (neg)
            half = -half;
        half = half / 2;
        return half[TEMP_W-1:0];
    endfunction

    class decode_scoreboard;
        t_decoded   expected_q[$];
        int         errors;
        logic [3:0] byte_pos;
        logic [7:0] crc_acc;
        logic [7:0] raw_lo;
        logic [7:0] raw_hi;
        logic [1:0] res_code;

        function new();
            errors   = 0;
            byte_pos = '0;
            crc_acc  = '0;
            raw_lo   = '0;
            raw_hi   = '0;
            res_code = '0;
        endfunction

        function void note_byte(input logic [7:0] b);
            t_decoded r;
            if (byte_pos >= FRAME_LAST) begin
                r = '0;
                if (b == crc_acc) begin
                    r.status = STATUS_OK;
                    r.temp   = milli_degrees({raw_hi, raw_lo}, res_code);
                    r.res    = RES_BASE + RES_W'(res_code);
                end else begin
                    r.status = STATUS_CRC;
                end
                expected_q.push_back(r);
                byte_pos = '0;
                crc_acc  = '0;
            end else begin
                if (byte_pos == IDX_RAW_LOW)
                    raw_lo = b;
                else if (byte_pos == IDX_RAW_HIGH)
                    raw_hi = b;
                else if (byte_pos == IDX_CONFIG)
                    res_code = b[6:5];
                crc_acc  = crc8_byte(crc_acc, b);
                byte_pos = byte_pos + 4'd1;
            end
        endfunction

        function void check_result(input logic [OUT_TDATA_W-1:0] d);
            t_decoded got;
            t_decoded want;
            got = t_decoded'(d);
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, d);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.temp !== want.temp) begin
                $display("%0t: temperature expected %0d actual %0d", $time, want.temp, got.temp);
                errors++;
            end
            if (got.res !== want.res) begin
                $display("%0t: resolution expected %0d actual %0d", $time, want.res, got.res);
                errors++;
            end
            if (got.pad !== want.pad) begin
                $display("%0t: pad bit expected %0d actual %0d", $time, want.pad, got.pad);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    decode_scoreboard sb;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        sb.note_byte(b);
        @(negedge i_clk);
    endtask

    // Send bytes 0..7 as given, then either the right CRC or a corrupted one.
    task automatic send_frame(input logic [15:0] raw, input logic [7:0] cfg,
                              input logic [7:0] fill, input bit rand_fill, input bit corrupt);
        logic [7:0] bytes[9];
        logic [7:0] crc;
        logic [7:0] flip;
        crc = '0;
        for (int i = 0; i < 8; i++) begin
            bytes[i] = rand_fill ? 8'($urandom_range(0, 255)) : fill;
        end
        bytes[IDX_RAW_LOW]  = raw[7:0];
        bytes[IDX_RAW_HIGH] = raw[15:8];
        bytes[IDX_CONFIG]   = cfg;
        for (int i = 0; i < 8; i++)
            crc = crc8_byte(crc, bytes[i]);
        flip     = 8'($urandom_range(1, 255));
        bytes[8] = corrupt ? (crc ^ flip) : crc;
        tx_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < 9; i++)
            send_byte(bytes[i]);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_raw();
        logic [15:0] w;
        case ($urandom_range(0, 5))
            0: w = 16'($urandom_range(0, 65535));
            1: w = 16'($urandom_range(0, 65535));
            // typical sensor span, -55 to +125 degrees
            2: w = 16'($signed($urandom_range(0, 2880)) - 880);
            3: w = 16'h8000 | 16'($urandom_range(0, 15));
            4: w = 16'h7FF0 | 16'($urandom_range(0, 15));
            default: begin
                case ($urandom_range(0, 5))
                    0: w = 16'h0000;
                    1: w = 16'hFFFF;
                    2: w = 16'h8000;
                    3: w = 16'h7FFF;
                    4: w = 16'h0FFF;
                    default: w = 16'hF000;
                endcase
            end
        endcase
        return w;
    endfunction

    // Receiver: unless in a burst, stall for a random wait; then take one result.
    initial begin
        int stall;
        i_m_tready = 1'b0;
        rx_burst   = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                rx_burst = ~rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
            sb.check_result(o_m_tdata);
            @(negedge i_clk);
        end
    end

    initial begin
        sb         = new();
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        tx_burst   = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: most negative word, largest positive word, CRC mismatch.
        send_frame(16'h8000, 8'h7F, 8'h00, 1'b0, 1'b0);
        send_frame(16'h7FFF, 8'h00, 8'hFF, 1'b0, 1'b0);
        send_frame(16'hFFFF, 8'h3F, 8'hFF, 1'b0, 1'b1);
        i_s_tvalid <= 1'b0;
        wait_drained();

        for (int f = 0; f < NUM_FRAMES; f++) begin
            send_frame(pick_raw(), 8'($urandom_range(0, 255)), 8'h00, 1'b1,
                       $urandom_range(0, 6) == 0);
            if (f == NUM_FRAMES / 2) begin
                i_s_tvalid <= 1'b0;
                wait_drained();
            end
        end
        i_s_tvalid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #1000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
